// ===== rtl/core/tsf_pkg.sv =====
`timescale 1ns / 1ps

package tsf_pkg;

    // Block configuration.
    localparam int SIDE_TAPS     = 5;
    localparam int JOINT_COUNT   = 7;
    localparam int POSITION_BITS = 20;

    // Joint lanes carried on the ports; lanes at or above JOINT_COUNT are held at zero.
    localparam int LANES = 7;

    // Samples held in the history line; the window is this plus the newest sample.
    localparam int SPAN = 2 * SIDE_TAPS;

    // Sum of all triangular weights, which is (SIDE_TAPS + 1) squared.
    localparam int WSUM = (SIDE_TAPS + 1) * (SIDE_TAPS + 1);

    // Weighted sum width, signed.
    localparam int SUM_W = POSITION_BITS + $clog2(WSUM);

    // Rounding numerator 2|s| + WSUM, unsigned.
    localparam int NUM_W = SUM_W + 1;

    // Rounded division by WSUM is floor((2|s| + WSUM) / (2 * WSUM)).
    localparam int DIV_D = 2 * WSUM;

    // Reciprocal multiply: floor(n * RECIP >> SHIFT) equals floor(n / DIV_D) for every
    // n below 2**NUM_W when SHIFT >= NUM_W + log2(DIV_D) and RECIP is rounded up.
    localparam int SHIFT   = NUM_W + $clog2(DIV_D);
    localparam int RECIP_W = NUM_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));
    localparam int PROD_W = NUM_W + RECIP_W;

    localparam int SEEN_W = $clog2(SPAN + 1);
    localparam int IDX_W  = (SIDE_TAPS > 0) ? $clog2(SIDE_TAPS + 1) : 1;
    localparam int WGT_W  = $clog2(SIDE_TAPS + 2);

    typedef logic [LANES-1:0][POSITION_BITS-1:0] joint_vec_t;
    typedef logic signed [SUM_W-1:0]              sum_t;

    // What a pipeline slot carries besides its data.
    typedef struct packed {
        logic smooth;   // 1: weighted average, 0: pass the held sample through
        logic last;     // last result of the trajectory
    } job_tag_t;

    // Triangular weight of window tap k, oldest tap first.
    function automatic logic [WGT_W-1:0] tap_weight(input int k);
        int offset;
        offset = (k >= SIDE_TAPS) ? (k - SIDE_TAPS) : (SIDE_TAPS - k);
        return WGT_W'(SIDE_TAPS + 1 - offset);
    endfunction

endpackage

// ===== rtl/core/triangular_smoothing_filter.sv =====
`timescale 1ns / 1ps

// Triangular smoothing filter for 7-joint waypoint streams. Each joint is averaged over a
// centered window of 2*SIDE_TAPS+1 waypoints with triangular weights that sum to
// (SIDE_TAPS+1)^2, and the result is rounded to nearest with ties away from zero. Positions
// are signed fixed point with 16 fractional bits. The smoothed value of waypoint i-SIDE_TAPS
// is produced when waypoint i arrives; the first SIDE_TAPS waypoints of a trajectory come
// out unchanged, and a request with final_sample set flushes the held tail unchanged, oldest
// first, with final_result marking the very last one. The block takes one request per clock
// cycle while the first stage can load and no flush is running; a result passes through the
// window snapshot, partial sum, total sum, rounding numerator, reciprocal product and output
// register stages. After a final request the input stays not ready while the flush sequencer
// feeds the held tail, up to SIDE_TAPS waypoints, into the arithmetic pipeline at one result
// per cycle whenever the first stage can load. Results wait in the output register, and the
// pipeline keeps taking requests until every stage behind that register is full.

module triangular_smoothing_filter
    import tsf_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [POSITION_BITS-1:0] joint0_position,
    input  logic signed [POSITION_BITS-1:0] joint1_position,
    input  logic signed [POSITION_BITS-1:0] joint2_position,
    input  logic signed [POSITION_BITS-1:0] joint3_position,
    input  logic signed [POSITION_BITS-1:0] joint4_position,
    input  logic signed [POSITION_BITS-1:0] joint5_position,
    input  logic signed [POSITION_BITS-1:0] joint6_position,
    input  logic                            final_sample,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [POSITION_BITS-1:0] joint0_smoothed,
    output logic signed [POSITION_BITS-1:0] joint1_smoothed,
    output logic signed [POSITION_BITS-1:0] joint2_smoothed,
    output logic signed [POSITION_BITS-1:0] joint3_smoothed,
    output logic signed [POSITION_BITS-1:0] joint4_smoothed,
    output logic signed [POSITION_BITS-1:0] joint5_smoothed,
    output logic signed [POSITION_BITS-1:0] joint6_smoothed,
    output logic                            final_result
);

    // ------------------------------------------------------------------
    // Front end: history line, trajectory counter and flush sequencer.
    // ------------------------------------------------------------------

    // history_reg[0] is the oldest held waypoint, history_reg[SPAN-1] the newest.
    joint_vec_t              history_reg [SPAN];
    logic [SEEN_W-1:0]       seen_reg;
    logic                    flush_busy_reg;
    logic [IDX_W-1:0]        flush_idx_reg;
    // flush_buf_reg[d] holds the waypoint d places behind the final one.
    joint_vec_t              flush_buf_reg [SIDE_TAPS+1];

    joint_vec_t              in_vec;
    joint_vec_t              win [SPAN+1];
    logic                    accept;
    logic                    have_center;
    logic                    have_full;

    // Job presented to the first pipeline stage.
    logic                    job_valid;
    job_tag_t                job_tag;
    joint_vec_t              job_pass;
    logic                    flush_issue;

    // Pipeline load enables, from the output back to the first stage.
    logic                    take1;
    logic                    take2;
    logic                    take3;
    logic                    take4;
    logic                    take5;
    logic                    take_out;

    // Stage 1: window snapshot.
    logic                    s1_valid_reg;
    job_tag_t                s1_tag_reg;
    joint_vec_t              s1_pass_reg;
    joint_vec_t              s1_win_reg [SPAN+1];

    // Stage 2: two partial weighted sums per joint.
    logic                    s2_valid_reg;
    job_tag_t                s2_tag_reg;
    joint_vec_t              s2_pass_reg;
    sum_t                    s2_lo_reg [LANES];
    sum_t                    s2_hi_reg [LANES];
    sum_t                    s2_lo_next [LANES];
    sum_t                    s2_hi_next [LANES];

    // Stage 3: full weighted sum.
    logic                    s3_valid_reg;
    job_tag_t                s3_tag_reg;
    joint_vec_t              s3_pass_reg;
    sum_t                    s3_total_reg [LANES];

    // Stage 4: rounding numerator and sign.
    logic                    s4_valid_reg;
    job_tag_t                s4_tag_reg;
    joint_vec_t              s4_pass_reg;
    logic [NUM_W-1:0]        s4_num_reg [LANES];
    logic [LANES-1:0]        s4_neg_reg;
    logic [NUM_W-1:0]        s4_num_next [LANES];

    // Stage 5: reciprocal product.
    logic                    s5_valid_reg;
    job_tag_t                s5_tag_reg;
    joint_vec_t              s5_pass_reg;
    logic [PROD_W-1:0]       s5_prod_reg [LANES];
    logic [LANES-1:0]        s5_neg_reg;

    // Output register.
    logic                    out_valid_reg;
    logic                    out_last_reg;
    joint_vec_t              out_joint_reg;
    joint_vec_t              out_joint_next;

    always_comb
    begin
        in_vec[0] = joint0_position;
        in_vec[1] = joint1_position;
        in_vec[2] = joint2_position;
        in_vec[3] = joint3_position;
        in_vec[4] = joint4_position;
        in_vec[5] = joint5_position;
        in_vec[6] = joint6_position;
        // Joints beyond the configured count are ignored and read as zero.
        for (int j = 0; j < LANES; j++)
        begin
            if (j >= JOINT_COUNT)
            begin
                in_vec[j] = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SPAN; i++)
        begin
            win[i] = history_reg[i];
        end
        win[SPAN] = in_vec;
    end

    assign take_out = !out_valid_reg || out_ready;
    assign take5    = !s5_valid_reg  || take_out;
    assign take4    = !s4_valid_reg  || take5;
    assign take3    = !s3_valid_reg  || take4;
    assign take2    = !s2_valid_reg  || take3;
    assign take1    = !s1_valid_reg  || take2;

    // New requests stop while the tail of a finished trajectory drains.
    assign in_ready    = take1 && !flush_busy_reg;
    assign accept      = in_valid && in_ready;
    assign flush_issue = flush_busy_reg && take1;

    assign have_center = (seen_reg >= SEEN_W'(SIDE_TAPS));
    assign have_full   = (seen_reg >= SEEN_W'(SPAN));

    // A request yields one regular result once the window center exists; it is a weighted
    // average only when the whole window is filled. Flush entries always pass through.
    always_comb
    begin
        job_valid      = 1'b0;
        job_tag.smooth = 1'b0;
        job_tag.last   = 1'b0;
        job_pass       = flush_buf_reg[flush_idx_reg];
        if (accept)
        begin
            job_valid      = have_center;
            job_tag.smooth = have_full;
            job_pass       = win[SIDE_TAPS];
        end
        else if (flush_issue)
        begin
            job_valid    = 1'b1;
            job_tag.last = (flush_idx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            flush_busy_reg <= 1'b0;
            flush_idx_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (final_sample)
                begin
                    seen_reg       <= '0;
                    flush_busy_reg <= 1'b1;
                    // The tail starts at the oldest waypoint not yet given a result.
                    flush_idx_reg  <= have_center ? IDX_W'(SIDE_TAPS - 1)
                                                  : IDX_W'(seen_reg);
                end
                else if (!have_full)
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
            end
            else if (flush_issue)
            begin
                if (flush_idx_reg == '0)
                begin
                    flush_busy_reg <= 1'b0;
                end
                else
                begin
                    flush_idx_reg <= flush_idx_reg - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (final_sample)
            begin
                for (int d = 0; d <= SIDE_TAPS; d++)
                begin
                    flush_buf_reg[d] <= win[SPAN-d];
                end
            end
            else
            begin
                for (int i = 0; i < SPAN; i++)
                begin
                    history_reg[i] <= win[i+1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic pipeline. Every stage loads whenever the stage after it
    // can take its contents, so bubbles close up behind a stalled output.
    // ------------------------------------------------------------------

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            s2_lo_next[j] = '0;
            s2_hi_next[j] = '0;
            for (int k = 0; k < SIDE_TAPS; k++)
            begin
                s2_lo_next[j] = s2_lo_next[j]
                              + sum_t'($signed(s1_win_reg[k][j])) * sum_t'(tap_weight(k));
            end
            for (int k = SIDE_TAPS; k <= SPAN; k++)
            begin
                s2_hi_next[j] = s2_hi_next[j]
                              + sum_t'($signed(s1_win_reg[k][j])) * sum_t'(tap_weight(k));
            end
        end
    end

    // Rounding to nearest with ties away from zero works on the magnitude:
    // q = floor((2|s| + WSUM) / (2 * WSUM)), then the sign is put back.
    always_comb
    begin
        logic [SUM_W-1:0] mag;
        for (int j = 0; j < LANES; j++)
        begin
            mag = s3_total_reg[j][SUM_W-1] ? (SUM_W'(0) - SUM_W'(s3_total_reg[j]))
                                           : SUM_W'(s3_total_reg[j]);
            s4_num_next[j] = {mag, 1'b0} + NUM_W'(WSUM);
        end
    end

    always_comb
    begin
        logic [POSITION_BITS-1:0] quot;
        for (int j = 0; j < LANES; j++)
        begin
            quot = s5_prod_reg[j][SHIFT +: POSITION_BITS];
            if (s5_tag_reg.smooth)
            begin
                out_joint_next[j] = s5_neg_reg[j] ? (POSITION_BITS'(0) - quot) : quot;
            end
            else
            begin
                out_joint_next[j] = s5_pass_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
            begin
                s1_valid_reg <= job_valid;
            end
            if (take2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (take3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (take4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (take5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (take_out)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            s1_tag_reg  <= job_tag;
            s1_pass_reg <= job_pass;
            for (int k = 0; k <= SPAN; k++)
            begin
                s1_win_reg[k] <= win[k];
            end
        end
        if (take2)
        begin
            s2_tag_reg  <= s1_tag_reg;
            s2_pass_reg <= s1_pass_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s2_lo_reg[j] <= s2_lo_next[j];
                s2_hi_reg[j] <= s2_hi_next[j];
            end
        end
        if (take3)
        begin
            s3_tag_reg  <= s2_tag_reg;
            s3_pass_reg <= s2_pass_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s3_total_reg[j] <= s2_lo_reg[j] + s2_hi_reg[j];
            end
        end
        if (take4)
        begin
            s4_tag_reg  <= s3_tag_reg;
            s4_pass_reg <= s3_pass_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s4_num_reg[j] <= s4_num_next[j];
                s4_neg_reg[j] <= s3_total_reg[j][SUM_W-1];
            end
        end
        if (take5)
        begin
            s5_tag_reg  <= s4_tag_reg;
            s5_pass_reg <= s4_pass_reg;
            s5_neg_reg  <= s4_neg_reg;
            for (int j = 0; j < LANES; j++)
            begin
                s5_prod_reg[j] <= PROD_W'(s4_num_reg[j]) * PROD_W'(RECIP);
            end
        end
        if (take_out)
        begin
            out_last_reg  <= s5_tag_reg.last;
            out_joint_reg <= out_joint_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign final_result    = out_last_reg;
    assign joint0_smoothed = $signed(out_joint_reg[0]);
    assign joint1_smoothed = $signed(out_joint_reg[1]);
    assign joint2_smoothed = $signed(out_joint_reg[2]);
    assign joint3_smoothed = $signed(out_joint_reg[3]);
    assign joint4_smoothed = $signed(out_joint_reg[4]);
    assign joint5_smoothed = $signed(out_joint_reg[5]);
    assign joint6_smoothed = $signed(out_joint_reg[6]);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // No request is taken while a trajectory tail is still being flushed.
    a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        flush_busy_reg |-> !in_ready)
        else $error("request taken during flush");

    // The trajectory counter saturates at the history depth.
    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(SPAN))
        else $error("trajectory counter out of range");

    // A final request restarts the trajectory and starts a flush.
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_sample) |=> (seen_reg == '0) && flush_busy_reg)
        else $error("final request did not restart the trajectory");

    // The flush ends right after its last entry enters the pipeline.
    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (flush_issue && (flush_idx_reg == '0)) |=> !flush_busy_reg)
        else $error("flush did not end after its last entry");

    // Stage 5, when it cannot move, holds its slot.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && !take5) |=> s5_valid_reg)
        else $error("stalled pipeline slot lost");

endmodule
